// ----- src/odo_pkg.sv -----
// shared types, constants and helper functions for the odometry block
package odo_pkg;

    // width of the shared multiply and divide datapath
    localparam int WW = 104;
    // quotient bits produced by one division
    localparam int QW = 34;
    // shift-add steps of one multiplication (multiplier operand width)
    localparam int MUL_STEPS = 33;
    localparam int DIV_STEPS = QW;
    // cordic iteration index width (arctangent table depth is 32)
    localparam int IW = 5;
    localparam int DEF_CORDIC_STEPS = 24;

    // pi in Q29 and the cordic gain compensation in Q30
    localparam logic [30:0] PI_Q29 = 31'd1686629713;
    localparam logic [29:0] K_Q30 = 30'd652032874;
    localparam logic [19:0] MEGA = 20'd1000000;

    // configuration register indexes
    localparam logic [2:0] CFG_RADIUS = 3'd0;
    localparam logic [2:0] CFG_BASE   = 3'd1;
    localparam logic [2:0] CFG_CPR    = 3'd2;
    localparam logic [2:0] CFG_LIN    = 3'd3;
    localparam logic [2:0] CFG_ROT    = 3'd4;

    // input item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_POSE   = 1'b1;

    // command to the shared multiply and divide unit
    typedef struct packed {
        logic start;
        logic div;
    } t_md_cmd;

    // arctangent of 2^-i as binary angle
    function automatic logic [29:0] atan_lut(input logic [IW-1:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85005780;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10680862;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41721;
            5'd15: v = 30'd20860;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2607;
            5'd19: v = 30'd1303;
            5'd20: v = 30'd651;
            5'd21: v = 30'd325;
            5'd22: v = 30'd162;
            5'd23: v = 30'd81;
            5'd24: v = 30'd40;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd2;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // saturate a 66 bit signed value to 32 bits
    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // clamp a rounded quotient magnitude and apply its sign
    function automatic logic [31:0] sat_quot(input logic [QW-1:0] q, input logic neg);
        logic [32:0] mag;
        logic [32:0] res;
        if (q > QW'(33'h0_8000_0000)) begin
            mag = 33'h0_8000_0000;
        end else begin
            mag = q[32:0];
        end
        if (neg) begin
            res = 33'd0 - mag;
        end else if (mag == 33'h0_8000_0000) begin
            res = 33'h0_7FFF_FFFF;
        end else begin
            res = mag;
        end
        return res[31:0];
    endfunction

endpackage

// ----- src/odo_muldiv.sv -----
// shared shift-add multiplier and restoring divider around one wide adder
module odo_muldiv (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  odo_pkg::t_md_cmd        i_cmd,
    input  logic [odo_pkg::WW-1:0]  i_a,
    input  logic [odo_pkg::WW-1:0]  i_b,
    input  logic [odo_pkg::WW-1:0]  i_init,
    output logic                    o_done,
    output logic [odo_pkg::WW-1:0]  o_result
);
    import odo_pkg::*;

    logic            r_busy, r_done, r_div;
    logic [5:0]      r_cnt;
    logic [WW-1:0]   r_acc, r_opa, r_opb;
    logic [QW-1:0]   r_q;
    logic [WW:0]     n_sum;
    logic [WW-1:0]   n_addend;

    // one wide adder: accumulate for multiply, trial subtract for divide
    always_comb begin
        n_addend = r_div ? ~r_opb : r_opa;
        n_sum    = {1'b0, r_acc} + {1'b0, n_addend} + {{WW{1'b0}}, r_div};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.div ? 6'(DIV_STEPS - 1) : 6'(MUL_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_div <= i_cmd.div;
            r_acc <= i_init;
            r_opa <= i_a;
            r_opb <= i_b;
            r_q   <= '0;
        end else if (r_busy) begin
            if (r_div) begin
                if (n_sum[WW]) begin
                    r_acc <= n_sum[WW-1:0];
                end
                r_q   <= {r_q[QW-2:0], n_sum[WW]};
                r_opb <= r_opb >> 1;
            end else begin
                if (r_opb[0]) begin
                    r_acc <= n_sum[WW-1:0];
                end
                r_opa <= r_opa << 1;
                r_opb <= r_opb >> 1;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_div ? {{(WW-QW){1'b0}}, r_q} : r_acc;

endmodule

// ----- src/odo_cordic.sv -----
// iterative cordic rotation that moves x and y by a step along the heading
module odo_cordic #(
    parameter int CORDIC_STEPS = odo_pkg::DEF_CORDIC_STEPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_mag,
    input  logic        i_neg,
    input  logic [31:0] i_angle,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    output logic        o_done,
    output logic [31:0] o_x,
    output logic [31:0] o_y
);
    import odo_pkg::*;

    logic                r_run, r_fin, r_done;
    logic [IW-1:0]       r_i;
    logic signed [63:0]  r_vx, r_vy;
    logic signed [33:0]  r_z;
    logic [31:0]         r_x, r_y, r_ox, r_oy;
    logic signed [33:0]  n_z0;
    logic                n_flip;
    logic signed [63:0]  n_sx, n_sy, n_rx, n_ry;
    logic signed [33:0]  n_at;

    // fold the angle into the right half plane
    always_comb begin
        n_z0   = 34'(signed'(i_angle));
        n_flip = 1'b0;
        if (n_z0 > 34'sd1073741824) begin
            n_z0   = n_z0 - 34'sd2147483648;
            n_flip = 1'b1;
        end else if (n_z0 < -34'sd1073741824) begin
            n_z0   = n_z0 + 34'sd2147483648;
            n_flip = 1'b1;
        end
    end

    // shifted terms and rounding of the final vector
    always_comb begin
        n_sx = r_vx >>> r_i;
        n_sy = r_vy >>> r_i;
        n_at = 34'(atan_lut(r_i));
        n_rx = (r_vx + 64'sd536870912) >>> 30;
        n_ry = (r_vy + 64'sd536870912) >>> 30;
    end

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_i == IW'(CORDIC_STEPS - 1)) begin
                r_run <= 1'b0;
                r_fin <= 1'b1;
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // rotation datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_i  <= '0;
            r_z  <= n_z0;
            r_vx <= (i_neg ^ n_flip) ? 64'sd0 - signed'(i_mag) : signed'(i_mag);
            r_vy <= '0;
            r_x  <= i_x;
            r_y  <= i_y;
        end else if (r_run) begin
            r_i <= r_i + 1'b1;
            if (r_z >= 0) begin
                r_vx <= r_vx - n_sy;
                r_vy <= r_vy + n_sx;
                r_z  <= r_z - n_at;
            end else begin
                r_vx <= r_vx + n_sy;
                r_vy <= r_vy - n_sx;
                r_z  <= r_z + n_at;
            end
        end else if (r_fin) begin
            r_ox <= sat32(66'(signed'(r_x)) + 66'(n_rx));
            r_oy <= sat32(66'(signed'(r_y)) + 66'(n_ry));
        end
    end

    assign o_done = r_done;
    assign o_x    = r_ox;
    assign o_y    = r_oy;

endmodule

// ----- src/differential_drive_odometry.sv -----
// odometry top level: sequencer, pose state, configuration and result register
// an encoder sample goes from acceptance to result through eight 33-step multiplications
// and two 34-step divisions on the one shared wide adder, then through the cordic rotation;
// set pose goes from acceptance straight to the output state
// one transaction at a time; the next is taken as soon as the sequencer is idle again
// reset restores default configuration and clears pose, counts, steps and turn count
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = odo_pkg::DEF_CORDIC_STEPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [31:0] i_left_count,
    input  logic [31:0] i_right_count,
    input  logic [31:0] i_pose_x,
    input  logic [31:0] i_pose_y,
    input  logic [31:0] i_pose_heading,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_pos_x,
    output logic [31:0] o_pos_y,
    output logic [31:0] o_heading,
    output logic [31:0] o_step_distance,
    output logic [31:0] o_step_rotation,
    output logic [15:0] o_turns,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [21:0] i_cfg_data
);
    import odo_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_D1   = 4'd1;
    localparam logic [3:0] S_L    = 4'd2;
    localparam logic [3:0] S_S    = 4'd3;
    localparam logic [3:0] S_P    = 4'd4;
    localparam logic [3:0] S_V1   = 4'd5;
    localparam logic [3:0] S_D2   = 4'd6;
    localparam logic [3:0] S_R    = 4'd7;
    localparam logic [3:0] S_T    = 4'd8;
    localparam logic [3:0] S_V2   = 4'd9;
    localparam logic [3:0] S_HD   = 4'd10;
    localparam logic [3:0] S_KM   = 4'd11;
    localparam logic [3:0] S_CO   = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    logic [3:0]        r_state;
    logic              r_issued;
    logic [19:0]       r_radius, r_cpr;
    logic [21:0]       r_base;
    logic [17:0]       r_lin, r_rot;
    logic [31:0]       r_prev_l, r_prev_r, r_x, r_y, r_hd, r_dist, r_rotn;
    logic [15:0]       r_turns;
    logic [32:0]       r_s_abs, r_d_abs;
    logic              r_s_neg, r_d_neg;
    logic [WW-1:0]     r_den, r_w;
    logic              r_ovalid;
    logic [31:0]       r_ox, r_oy, r_ohd, r_odist, r_orot;
    logic [15:0]       r_oturns;

    t_md_cmd           n_cmd;
    logic [WW-1:0]     n_a, n_b, n_init, w_res;
    logic              w_md_done, w_co_done, n_co_start, n_md_state;
    logic [31:0]       w_co_x, w_co_y;
    logic [19:0]       n_cpr;
    logic [21:0]       n_base;
    logic [31:0]       n_dl, n_dr;
    logic [32:0]       n_s, n_d, n_hsum, n_dist_abs;
    logic              n_accept, n_out_free;

    assign n_accept   = i_valid && !o_stall;
    assign n_out_free = !r_ovalid || !i_stall;
    assign n_cpr      = (r_cpr == 20'd0) ? 20'd1 : r_cpr;
    assign n_base     = (r_base == 22'd0) ? 22'd1 : r_base;

    // wrapping count differences, their sum and difference
    always_comb begin
        n_dl = i_left_count - r_prev_l;
        n_dr = i_right_count - r_prev_r;
        n_s  = 33'(signed'(n_dl)) + 33'(signed'(n_dr));
        n_d  = 33'(signed'(n_dr)) - 33'(signed'(n_dl));
    end

    // heading update and step magnitude for the cordic prescale
    always_comb begin
        n_hsum     = 33'(signed'(r_hd)) + 33'(signed'(r_rotn));
        n_dist_abs = r_dist[31] ? 33'd0 - 33'(signed'(r_dist)) : {1'b0, r_dist};
    end

    // operand selection for the shared unit
    always_comb begin
        n_a        = '0;
        n_b        = '0;
        n_init     = '0;
        n_md_state = 1'b1;
        unique case (r_state)
            S_D1: begin
                n_a = WW'(n_cpr);
                n_b = WW'(MEGA);
            end
            S_L: begin
                n_a = WW'(r_lin);
                n_b = WW'(r_radius);
            end
            S_S: begin
                n_a = r_w;
                n_b = WW'(r_s_abs);
            end
            S_P: begin
                n_a    = r_w;
                n_b    = WW'(PI_Q29);
                n_init = r_den >> 1;
            end
            S_V1, S_V2: begin
                n_init = r_w;
                n_b    = r_den << QW - 1;
            end
            S_D2: begin
                n_a = WW'(n_cpr);
                n_b = WW'(n_base);
            end
            S_R: begin
                n_a = WW'(r_rot);
                n_b = WW'(r_radius);
            end
            S_T: begin
                n_a    = r_w << 16;
                n_b    = WW'(r_d_abs);
                n_init = r_den >> 1;
            end
            S_KM: begin
                n_a = WW'(K_Q30);
                n_b = WW'(n_dist_abs);
            end
            default: begin
                n_md_state = 1'b0;
            end
        endcase
        n_cmd.start = n_md_state && !r_issued;
        n_cmd.div   = (r_state == S_V1) || (r_state == S_V2);
        n_co_start  = (r_state == S_CO) && !r_issued;
    end

    odo_muldiv u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (n_cmd),
        .i_a      (n_a),
        .i_b      (n_b),
        .i_init   (n_init),
        .o_done   (w_md_done),
        .o_result (w_res)
    );

    odo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_co_start),
        .i_mag   (r_w[63:0]),
        .i_neg   (r_dist[31]),
        .i_angle (r_hd),
        .i_x     (r_x),
        .i_y     (r_y),
        .o_done  (w_co_done),
        .o_x     (w_co_x),
        .o_y     (w_co_y)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 20'd30000;
            r_base   <= 22'd200000;
            r_cpr    <= 20'd27610;
            r_lin    <= 18'd65536;
            r_rot    <= 18'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RADIUS: r_radius <= i_cfg_data[19:0];
                CFG_BASE:   r_base   <= i_cfg_data;
                CFG_CPR:    r_cpr    <= i_cfg_data[19:0];
                CFG_LIN:    r_lin    <= i_cfg_data[17:0];
                CFG_ROT:    r_rot    <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // sequencer and pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_prev_l <= '0;
            r_prev_r <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_hd     <= '0;
            r_dist   <= '0;
            r_rotn   <= '0;
            r_turns  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_OUT && n_out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (n_cmd.start || n_co_start) begin
                r_issued <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        if (i_kind == KIND_POSE) begin
                            r_x     <= i_pose_x;
                            r_y     <= i_pose_y;
                            r_hd    <= i_pose_heading;
                            r_state <= S_OUT;
                        end else begin
                            r_prev_l <= i_left_count;
                            r_prev_r <= i_right_count;
                            r_s_neg  <= n_s[32];
                            r_d_neg  <= n_d[32];
                            r_s_abs  <= n_s[32] ? 33'd0 - n_s : n_s;
                            r_d_abs  <= n_d[32] ? 33'd0 - n_d : n_d;
                            r_state  <= S_D1;
                        end
                    end
                end
                S_D1, S_D2: begin
                    // distance divisor carries the pi scaling, rotation divisor does not
                    if (w_md_done) begin
                        r_den    <= (r_state == S_D1) ? w_res << 29 : w_res;
                        r_issued <= 1'b0;
                        r_state  <= (r_state == S_D1) ? S_L : S_R;
                    end
                end
                S_L, S_S, S_P, S_R, S_T, S_KM: begin
                    if (w_md_done) begin
                        r_w      <= w_res;
                        r_issued <= 1'b0;
                        unique case (r_state)
                            S_L:     r_state <= S_S;
                            S_S:     r_state <= S_P;
                            S_P:     r_state <= S_V1;
                            S_R:     r_state <= S_T;
                            S_T:     r_state <= S_V2;
                            default: r_state <= S_CO;
                        endcase
                    end
                end
                S_V1: begin
                    if (w_md_done) begin
                        r_dist   <= sat_quot(w_res[QW-1:0], r_s_neg);
                        r_issued <= 1'b0;
                        r_state  <= S_D2;
                    end
                end
                S_V2: begin
                    if (w_md_done) begin
                        r_rotn   <= sat_quot(w_res[QW-1:0], r_d_neg);
                        r_issued <= 1'b0;
                        r_state  <= S_HD;
                    end
                end
                S_HD: begin
                    // wrap past plus or minus pi moves the turn counter
                    r_hd <= n_hsum[31:0];
                    if (n_hsum[32:31] == 2'b01 && r_turns != 16'h7FFF) begin
                        r_turns <= r_turns + 16'd1;
                    end else if (n_hsum[32:31] == 2'b10 && r_turns != 16'h8000) begin
                        r_turns <= r_turns - 16'd1;
                    end
                    r_state <= S_KM;
                end
                S_CO: begin
                    if (w_co_done) begin
                        r_x      <= w_co_x;
                        r_y      <= w_co_y;
                        r_issued <= 1'b0;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (n_out_free) begin
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && n_out_free) begin
            r_ox     <= r_x;
            r_oy     <= r_y;
            r_ohd    <= r_hd;
            r_odist  <= r_dist;
            r_orot   <= r_rotn;
            r_oturns <= r_turns;
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_ovalid;
    assign o_pos_x         = r_ox;
    assign o_pos_y         = r_oy;
    assign o_heading       = r_ohd;
    assign o_step_distance = r_odist;
    assign o_step_rotation = r_orot;
    assign o_turns         = r_oturns;

`ifndef SYNTH
    // an accepted transaction always occupies the sequencer on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |=> o_stall)
        else $error("sequencer idle after accepted transaction");

    // the shared unit only reports completion in a multiply or divide step
    a_md_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_done |-> n_md_state && r_issued)
        else $error("shared unit completed outside its step");

    // the turn counter moves by at most one per transaction
    a_turn_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_turns == $past(r_turns) || r_turns == $past(r_turns) + 16'd1
            || r_turns == $past(r_turns) - 16'd1))
        else $error("turn counter jumped");
`endif

endmodule

// ----- dv/tb_differential_drive_odometry.sv -----
// testbench for the odometry block: self-checking against an internal pose predictor
module tb_differential_drive_odometry;
    timeunit 1ns;
    timeprecision 1ps;
    import odo_pkg::*;

    localparam int STEPS = DEF_CORDIC_STEPS;
    localparam longint HALF_TURN = 64'sd2147483648;

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] heading;
        logic [31:0] step_distance;
        logic [31:0] step_rotation;
        logic [15:0] turns;
    } t_pose;

    // arctangent of 2^-i in binary angle units
    localparam longint ATAN [32] = '{
        536870912, 316933406, 167458907, 85005780, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162,
        81, 40, 20, 10, 5, 2, 1, 0, 0};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_kind = KIND_SAMPLE;
    logic [31:0] i_left_count = '0;
    logic [31:0] i_right_count = '0;
    logic [31:0] i_pose_x = '0;
    logic [31:0] i_pose_y = '0;
    logic [31:0] i_pose_heading = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_pos_x;
    logic [31:0] o_pos_y;
    logic [31:0] o_heading;
    logic [31:0] o_step_distance;
    logic [31:0] o_step_rotation;
    logic [15:0] o_turns;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = CFG_RADIUS;
    logic [21:0] i_cfg_data = '0;

    differential_drive_odometry u_top (.*);

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predicted configuration and pose
    longint cfg_radius = 30000, cfg_base = 200000, cfg_cpr = 27610;
    longint cfg_lin = 65536, cfg_rot = 65536;
    logic [31:0] last_left = '0, last_right = '0;
    longint pose_x = 0, pose_y = 0, pose_hdg = 0, turn_cnt = 0;
    longint last_dist = 0, last_rot = 0;

    t_pose  pose_q[$];
    int     n_fail = 0;
    int     n_done = 0;
    int     n_pose = 0;
    bit     no_idle = 1'b0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -HALF_TURN) return -HALF_TURN;
        return v;
    endfunction

    // rounded quotient, half away from zero, saturated to 32 bits
    function automatic longint round_quot(logic [127:0] num, logic [127:0] den, bit neg);
        logic [127:0] q;
        q = (num + (den >> 1)) / den;
        if (q > 128'h8000_0000) q = 128'h8000_0000;
        if (neg) return -longint'(q[32:0]);
        return clamp32(longint'(q[32:0]));
    endfunction

    // advance the pose by one transaction and return the expected result
    function automatic t_pose odo_predict(logic kind, logic [31:0] l, logic [31:0] r,
                                          logic [31:0] px, logic [31:0] py,
                                          logic [31:0] ph);
        longint dl, dr, s, d, hsum, vx, vy, z, nx, cpr, base;
        logic [127:0] num, den;
        t_pose p;
        if (kind == KIND_SAMPLE) begin
            dl = longint'(signed'(l - last_left));
            dr = longint'(signed'(r - last_right));
            last_left = l;
            last_right = r;
            s = dl + dr;
            d = dr - dl;
            cpr = (cfg_cpr == 0) ? 1 : cfg_cpr;
            base = (cfg_base == 0) ? 1 : cfg_base;
            num = (s < 0) ? -s : s;
            num = num * cfg_lin * cfg_radius * 128'd1686629713;
            den = 128'(cpr) * 128'd1000000 << 29;
            last_dist = round_quot(num, den, s < 0);
            num = (d < 0) ? -d : d;
            num = (num * cfg_rot * cfg_radius) << 16;
            den = 128'(cpr) * 128'(base);
            last_rot = round_quot(num, den, d < 0);
            // heading wrap moves the turn counter
            hsum = pose_hdg + last_rot;
            if (hsum > 64'sd2147483647) begin
                hsum -= 2 * HALF_TURN;
                if (turn_cnt < 32767) turn_cnt++;
            end else if (hsum < -HALF_TURN) begin
                hsum += 2 * HALF_TURN;
                if (turn_cnt > -32768) turn_cnt--;
            end
            pose_hdg = hsum;
            // cordic rotation of the step onto the heading
            vx = last_dist * 64'sd652032874;
            vy = 0;
            z = pose_hdg;
            if (z > 64'sd1073741824) begin
                z -= HALF_TURN;
                vx = -vx;
            end else if (z < -64'sd1073741824) begin
                z += HALF_TURN;
                vx = -vx;
            end
            for (int i = 0; i < STEPS && i < 32; i++) begin
                if (z >= 0) begin
                    nx = vx - (vy >>> i);
                    vy = vy + (vx >>> i);
                    z -= ATAN[i];
                end else begin
                    nx = vx + (vy >>> i);
                    vy = vy - (vx >>> i);
                    z += ATAN[i];
                end
                vx = nx;
            end
            pose_x = clamp32(pose_x + ((vx + 64'sd536870912) >>> 30));
            pose_y = clamp32(pose_y + ((vy + 64'sd536870912) >>> 30));
        end else begin
            pose_x = longint'(signed'(px));
            pose_y = longint'(signed'(py));
            pose_hdg = longint'(signed'(ph));
        end
        p.pos_x = pose_x[31:0];
        p.pos_y = pose_y[31:0];
        p.heading = pose_hdg[31:0];
        p.step_distance = last_dist[31:0];
        p.step_rotation = last_rot[31:0];
        p.turns = turn_cnt[15:0];
        return p;
    endfunction

    // send one transaction, after a random gap unless no_idle is set
    task automatic send_item(logic kind, logic [31:0] l, logic [31:0] r,
                             logic [31:0] px, logic [31:0] py, logic [31:0] ph);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_kind <= kind;
        i_left_count <= l;
        i_right_count <= r;
        i_pose_x <= px;
        i_pose_y <= py;
        i_pose_heading <= ph;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        pose_q.push_back(odo_predict(kind, l, r, px, py, ph));
        if (kind == KIND_POSE) n_pose++;
    endtask

    task automatic send_sample(logic [31:0] l, logic [31:0] r);
        send_item(KIND_SAMPLE, l, r, $urandom, $urandom, $urandom);
    endtask

    task automatic send_pose(logic [31:0] px, logic [31:0] py, logic [31:0] ph);
        send_item(KIND_POSE, $urandom, $urandom, px, py, ph);
    endtask

    // wait until every expected result has come back
    task automatic drain();
        i_valid <= 1'b0;
        while (pose_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // register write, only while idle
    task automatic cfg_write(logic [2:0] idx, logic [21:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_RADIUS: cfg_radius = val[19:0];
            CFG_BASE:   cfg_base = val[21:0];
            CFG_CPR:    cfg_cpr = val[19:0];
            CFG_LIN:    cfg_lin = val[17:0];
            CFG_ROT:    cfg_rot = val[17:0];
            default: ;
        endcase
    endtask

    task automatic cfg_all(int rad, int base, int cpr, int lin, int rot);
        drain();
        cfg_write(CFG_RADIUS, 22'(rad));
        cfg_write(CFG_BASE, 22'(base));
        cfg_write(CFG_CPR, 22'(cpr));
        cfg_write(CFG_LIN, 22'(lin));
        cfg_write(CFG_ROT, 22'(rot));
    endtask

    // directed corners: first sample, count wrap, exact half turn, set pose extremes
    task automatic test_directed();
        logic [31:0] ph;
        send_sample(32'd100, 32'd120);
        send_sample(32'd100, 32'd120);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'hFFFF_FFFF, 32'h0000_0000);
        send_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'd5000, 32'd5000);
        send_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'd2000, 32'd0);
        send_pose(32'd0, 32'd0, 32'h4000_0001);
        send_sample(32'd3000, 32'd3000);
        send_pose(32'd0, 32'd0, 32'hC000_0000);
        send_sample(32'd4000, 32'd4000);
        // land exactly on plus pi: repeat a known rotation from a chosen heading
        send_sample(32'd4100, 32'd4300);
        ph = 32'h8000_0000 - last_rot[31:0];
        send_pose(32'd0, 32'd0, ph);
        send_sample(32'd4200, 32'd4600);
        send_pose(32'hFFFF_FFFF, 32'h0000_0000, 32'd0);
        drain();
    endtask

    // saturating configuration extremes and zero divisors
    task automatic test_config_extremes();
        cfg_all(1000000, 1, 1, 262143, 262143);
        send_sample(last_left + 32'd1, last_right + 32'd3);
        send_sample(last_left + 32'h4000_0000, last_right - 32'h4000_0000);
        send_sample(last_left - 32'd7, last_right - 32'd7);
        cfg_all(1, 0, 0, 0, 0);
        send_sample(last_left + 32'd9, last_right + 32'd1);
        cfg_all(1, 4000000, 1048575, 1, 1);
        send_sample(last_left + 32'd100000, last_right - 32'd100000);
        drain();
    endtask

    // random phases: mostly plausible motion, some wild counts and pose writes
    task automatic test_random(int n_items);
        int sel;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: cfg_all(30000, 200000, 27610, 65536, 65536);
                1: cfg_all(1000000, 4000000, 1048575, 262143, 262143);
                2: cfg_all(1, 1, 1, 65536, 65536);
                3: cfg_all(500000, 1, 4, 262143, 0);
                default: cfg_all($urandom_range(0, 1048575), $urandom_range(0, 4194303),
                                 $urandom_range(0, 1048575), $urandom_range(0, 262143),
                                 $urandom_range(0, 262143));
            endcase
            for (int k = 0; k < n_items / 5; k++) begin
                if (k % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
                sel = $urandom_range(0, 99);
                if (sel < 80) begin
                    send_sample(last_left + 32'($urandom_range(0, 4000)) - 32'd2000,
                                last_right + 32'($urandom_range(0, 4000)) - 32'd2000);
                end else if (sel < 90) begin
                    send_sample($urandom, $urandom);
                end else begin
                    send_pose($urandom, $urandom, $urandom);
                end
            end
            no_idle = 1'b0;
        end
        drain();
    endtask

    // result checker with random stall unless no_idle is set
    initial begin : result_check
        int    hold;
        t_pose exp_p;
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 17);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            if (pose_q.size() == 0) begin
                $error("unexpected transaction x=%h y=%h", o_pos_x, o_pos_y);
                n_fail++;
            end else begin
                exp_p = pose_q.pop_front();
                n_done++;
                if (o_pos_x !== exp_p.pos_x) begin
                    $error("pos_x exp %h got %h", exp_p.pos_x, o_pos_x);
                    n_fail++;
                end
                if (o_pos_y !== exp_p.pos_y) begin
                    $error("pos_y exp %h got %h", exp_p.pos_y, o_pos_y);
                    n_fail++;
                end
                if (o_heading !== exp_p.heading) begin
                    $error("heading exp %h got %h", exp_p.heading, o_heading);
                    n_fail++;
                end
                if (o_step_distance !== exp_p.step_distance) begin
                    $error("step_distance exp %h got %h", exp_p.step_distance,
                           o_step_distance);
                    n_fail++;
                end
                if (o_step_rotation !== exp_p.step_rotation) begin
                    $error("step_rotation exp %h got %h", exp_p.step_rotation,
                           o_step_rotation);
                    n_fail++;
                end
                if (o_turns !== exp_p.turns) begin
                    $error("turns exp %h got %h", exp_p.turns, o_turns);
                    n_fail++;
                end
            end
        end
    end

    // run limit
    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // test sequence
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_random(1750);
        repeat (400) @(posedge i_clk);
        if (pose_q.size() != 0) begin
            $error("%0d results never arrived", pose_q.size());
            n_fail++;
        end
        $display("covered %0d transactions (%0d pose writes) over several register settings",
                 n_done, n_pose);
        $display("final turn count %0d, mismatches %0d", turn_cnt, n_fail);
        if (n_fail == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/odo_pkg.sv
src/odo_muldiv.sv
src/odo_cordic.sv
src/differential_drive_odometry.sv
dv/tb_differential_drive_odometry.sv
